// ----- rtl/ste_pkg.sv -----
`timescale 1ns / 1ps
// shared types, control codes and helpers of the text screen editor engine
// no dependencies; used by every rtl file of the block but ste_ram
package ste_pkg;

	localparam int DEF_MAX_COLS = 64;
	localparam int DEF_MAX_ROWS = 32;
	localparam int COLS_RESET   = 40;
	localparam int ROWS_RESET   = 24;
	localparam int CHAR_W       = 8;

	// control codes
	localparam logic [7:0] C_ESC   = 8'h1B;
	localparam logic [7:0] C_UP    = 8'h1C;
	localparam logic [7:0] C_DOWN  = 8'h1D;
	localparam logic [7:0] C_LEFT  = 8'h1E;
	localparam logic [7:0] C_RIGHT = 8'h1F;
	localparam logic [7:0] C_CLEAR = 8'h7D;
	localparam logic [7:0] C_BS    = 8'h7E;
	localparam logic [7:0] C_EOL   = 8'h9B;
	localparam logic [7:0] C_DELLN = 8'h9C;
	localparam logic [7:0] C_INSLN = 8'h9D;
	localparam logic [7:0] C_BELL  = 8'hFD;
	localparam logic [7:0] C_DELCH = 8'hFE;
	localparam logic [7:0] C_INSCH = 8'hFF;
	localparam logic [7:0] C_SPACE = 8'h20;
	localparam logic [7:0] FILL_CLEAR = 8'h00;

	localparam logic OP_READ  = 1'b1;
	localparam logic CFG_COLS = 1'b0;
	localparam logic CFG_ROWS = 1'b1;

	typedef logic [3:0] kind_t;
	localparam kind_t K_GLYPH = 4'd0;
	localparam kind_t K_READ  = 4'd1;
	localparam kind_t K_ESC   = 4'd2;
	localparam kind_t K_UP    = 4'd3;
	localparam kind_t K_DOWN  = 4'd4;
	localparam kind_t K_LEFT  = 4'd5;
	localparam kind_t K_RIGHT = 4'd6;
	localparam kind_t K_CLEAR = 4'd7;
	localparam kind_t K_BS    = 4'd8;
	localparam kind_t K_EOL   = 4'd9;
	localparam kind_t K_DELLN = 4'd10;
	localparam kind_t K_INSLN = 4'd11;
	localparam kind_t K_BELL  = 4'd12;
	localparam kind_t K_DELCH = 4'd13;
	localparam kind_t K_INSCH = 4'd14;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		logic        raw_glyph;
		logic        rd_ok;
		logic [4:0]  rrow;
		logic [5:0]  rcol;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic in_area;
	} sts_t;

	// last usable index for a size register; zero acts as one
	function automatic int eff_last(int value, int max_v);
		if (value == 0) return 0;
		if (value > max_v) return max_v - 1;
		return value - 1;
	endfunction

endpackage

// ----- rtl/ste_ram.sv -----
`timescale 1ns / 1ps
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module ste_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/ste_front.sv -----
`timescale 1ns / 1ps
// front end: accepts items, decodes the byte into a command, holds a two entry queue
// depends on ste_pkg
module ste_front #(
	parameter int MAX_COLS = ste_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = ste_pkg::DEF_MAX_ROWS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             operation,
	input  logic [7:0]       char_code,
	input  logic             display_raw,
	input  logic [4:0]       read_row,
	input  logic [5:0]       read_col,
	output logic             cmd_valid,
	input  logic             cmd_pop,
	output ste_pkg::cmd_t    cmd
);

	ste_pkg::cmd_t dec;
	ste_pkg::cmd_t q_mem_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          push;

	always_comb begin
		dec.ch        = char_code;
		dec.raw_glyph = display_raw && (char_code != ste_pkg::C_EOL);
		dec.rd_ok     = (int'(read_row) < MAX_ROWS) && (int'(read_col) < MAX_COLS);
		dec.rrow      = read_row;
		dec.rcol      = read_col;
		if (operation == ste_pkg::OP_READ) begin
			dec.kind = ste_pkg::K_READ;
		end else begin
			unique case (char_code)
				ste_pkg::C_ESC:   dec.kind = ste_pkg::K_ESC;
				ste_pkg::C_UP:    dec.kind = ste_pkg::K_UP;
				ste_pkg::C_DOWN:  dec.kind = ste_pkg::K_DOWN;
				ste_pkg::C_LEFT:  dec.kind = ste_pkg::K_LEFT;
				ste_pkg::C_RIGHT: dec.kind = ste_pkg::K_RIGHT;
				ste_pkg::C_CLEAR: dec.kind = ste_pkg::K_CLEAR;
				ste_pkg::C_BS:    dec.kind = ste_pkg::K_BS;
				ste_pkg::C_EOL:   dec.kind = ste_pkg::K_EOL;
				ste_pkg::C_DELLN: dec.kind = ste_pkg::K_DELLN;
				ste_pkg::C_INSLN: dec.kind = ste_pkg::K_INSLN;
				ste_pkg::C_BELL:  dec.kind = ste_pkg::K_BELL;
				ste_pkg::C_DELCH: dec.kind = ste_pkg::K_DELCH;
				ste_pkg::C_INSCH: dec.kind = ste_pkg::K_INSCH;
				default:          dec.kind = ste_pkg::K_GLYPH;
			endcase
		end
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (cmd_pop) begin
				rp_q <= ~rp_q;
			end
			unique case ({push, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/ste_back.sv -----
`timescale 1ns / 1ps
// back end: cursor, escape flag, size registers and the screen store sequencer
// depends on ste_pkg and ste_ram
module ste_back #(
	parameter int MAX_COLS = ste_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = ste_pkg::DEF_MAX_ROWS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [0:0]    cfg_index,
	input  logic [6:0]    cfg_data,
	input  logic          cmd_valid,
	input  ste_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    cell_value,
	output logic [5:0]    cursor_col,
	output logic [4:0]    cursor_row,
	output logic          bell,
	output logic          escape_armed,
	output ste_pkg::sts_t sts
);

	localparam int CW    = $clog2(MAX_COLS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [2:0] ST_SWEEP = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_MV_RD = 3'd3;
	localparam logic [2:0] ST_MV_WR = 3'd4;
	localparam logic [2:0] ST_BLANK = 3'd5;

	logic [2:0]    st_q, st_d;
	logic [CW-1:0] x_q, x_d, wm1_q, wm1_d, ci_q, ci_d, stopc_q, stopc_d;
	logic [RW-1:0] y_q, y_d, hm1_q, hm1_d, ri_q, ri_d, stopr_q, stopr_d;
	logic          esc_q, esc_d, line_q, line_d, fwd_q, fwd_d;
	logic [AW-1:0] sweep_q, sweep_d;
	logic [7:0]    fill_q, fill_d;
	logic          clr_q, clr_d, rd_ok_q, rd_ok_d;
	logic          ov_q;
	logic [7:0]    cell_q;
	logic [5:0]    cx_q;
	logic [4:0]    cy_q;
	logic          bell_q, esca_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;
	logic          take, emit, e_bell, adv_col, adv_row;
	logic [7:0]    e_cell;
	logic [CW-1:0] nw;
	logic [RW-1:0] nh;

	function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] r, logic [CW-1:0] c);
		return AW'(AW'(r) * AW'(MAX_COLS) + AW'(c));
	endfunction

	ste_ram #(
		.WIDTH(ste_pkg::CHAR_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		st_d    = st_q;
		x_d     = x_q;
		y_d     = y_q;
		esc_d   = esc_q;
		wm1_d   = wm1_q;
		hm1_d   = hm1_q;
		line_d  = line_q;
		fwd_d   = fwd_q;
		ri_d    = ri_q;
		ci_d    = ci_q;
		stopr_d = stopr_q;
		stopc_d = stopc_q;
		sweep_d = sweep_q;
		fill_d  = fill_q;
		clr_d   = clr_q;
		rd_ok_d = rd_ok_q;
		we      = 1'b0;
		waddr   = '0;
		wdata   = '0;
		re      = 1'b0;
		raddr   = '0;
		take    = 1'b0;
		emit    = 1'b0;
		e_cell  = 8'h00;
		e_bell  = 1'b0;
		adv_col = 1'b0;
		adv_row = 1'b0;
		nw      = '0;
		nh      = '0;

		unique case (st_q)
			ST_SWEEP: begin
				we      = 1'b1;
				waddr   = sweep_q;
				wdata   = fill_q;
				sweep_d = sweep_q + 1'b1;
				if (sweep_q == AW'(DEPTH - 1)) begin
					st_d  = ST_IDLE;
					emit  = clr_q;
					clr_d = 1'b0;
				end
			end
			ST_IDLE: begin
				if (cmd_valid && (!ov_q || out_ready)) begin
					take = 1'b1;
					if (cmd.kind == ste_pkg::K_READ) begin
						re      = 1'b1;
						raddr   = cell_addr(RW'(cmd.rrow), CW'(cmd.rcol));
						rd_ok_d = cmd.rd_ok;
						st_d    = ST_READ;
					end else if (esc_q || cmd.raw_glyph || cmd.kind == ste_pkg::K_GLYPH) begin
						esc_d   = 1'b0;
						we      = 1'b1;
						waddr   = cell_addr(y_q, x_q);
						wdata   = cmd.ch;
						adv_col = 1'b1;
					end else begin
						unique case (cmd.kind)
							ste_pkg::K_ESC:   esc_d = 1'b1;
							ste_pkg::K_UP:    y_d = (y_q == '0) ? hm1_q : y_q - 1'b1;
							ste_pkg::K_DOWN:  y_d = (y_q == hm1_q) ? '0 : y_q + 1'b1;
							ste_pkg::K_LEFT:  x_d = (x_q == '0) ? wm1_q : x_q - 1'b1;
							ste_pkg::K_RIGHT: x_d = (x_q == wm1_q) ? '0 : x_q + 1'b1;
							ste_pkg::K_CLEAR: begin
								fill_d  = ste_pkg::FILL_CLEAR;
								sweep_d = '0;
								clr_d   = 1'b1;
								x_d     = '0;
								y_d     = '0;
								st_d    = ST_SWEEP;
							end
							ste_pkg::K_BS: begin
								we    = 1'b1;
								waddr = cell_addr(y_q, x_q);
								wdata = ste_pkg::C_SPACE;
								if (x_q != '0) begin
									x_d = x_q - 1'b1;
								end
							end
							ste_pkg::K_EOL: begin
								x_d     = '0;
								adv_row = 1'b1;
							end
							ste_pkg::K_DELLN: begin
								line_d  = 1'b1;
								fwd_d   = 1'b1;
								ri_d    = y_q;
								ci_d    = '0;
								stopr_d = hm1_q;
								st_d    = ST_MV_RD;
							end
							ste_pkg::K_INSLN: begin
								line_d  = 1'b1;
								fwd_d   = 1'b0;
								ri_d    = hm1_q;
								ci_d    = '0;
								stopr_d = y_q;
								st_d    = ST_MV_RD;
							end
							ste_pkg::K_DELCH: begin
								line_d  = 1'b0;
								fwd_d   = 1'b1;
								ci_d    = x_q;
								stopc_d = wm1_q;
								st_d    = ST_MV_RD;
							end
							ste_pkg::K_INSCH: begin
								line_d  = 1'b0;
								fwd_d   = 1'b0;
								ci_d    = wm1_q;
								stopc_d = x_q;
								st_d    = ST_MV_RD;
							end
							ste_pkg::K_BELL:  e_bell = 1'b1;
							default: begin
							end
						endcase
					end
					if (adv_col) begin
						if (x_q == wm1_q) begin
							x_d     = '0;
							adv_row = 1'b1;
						end else begin
							x_d = x_q + 1'b1;
						end
					end
					if (adv_row) begin
						if (y_q == hm1_q) begin
							// bottom row: scroll is a line delete at the top row
							line_d  = 1'b1;
							fwd_d   = 1'b1;
							ri_d    = '0;
							ci_d    = '0;
							stopr_d = hm1_q;
							st_d    = ST_MV_RD;
						end else begin
							y_d = y_q + 1'b1;
						end
					end
					if (st_d == ST_IDLE) begin
						emit = 1'b1;
					end
				end
			end
			ST_READ: begin
				emit   = 1'b1;
				e_cell = rd_ok_q ? rdata : 8'h00;
				st_d   = ST_IDLE;
			end
			ST_MV_RD: begin
				if (line_q ? (ri_q != stopr_q) : (ci_q != stopc_q)) begin
					re = 1'b1;
					if (line_q) begin
						raddr = cell_addr(fwd_q ? RW'(ri_q + 1'b1) : RW'(ri_q - 1'b1), ci_q);
					end else begin
						raddr = cell_addr(y_q, fwd_q ? CW'(ci_q + 1'b1) : CW'(ci_q - 1'b1));
					end
					st_d = ST_MV_WR;
				end else begin
					st_d = ST_BLANK;
				end
			end
			ST_MV_WR: begin
				we    = 1'b1;
				waddr = cell_addr(line_q ? ri_q : y_q, ci_q);
				wdata = rdata;
				if (line_q) begin
					if (ci_q == wm1_q) begin
						ci_d = '0;
						ri_d = fwd_q ? RW'(ri_q + 1'b1) : RW'(ri_q - 1'b1);
					end else begin
						ci_d = ci_q + 1'b1;
					end
				end else begin
					ci_d = fwd_q ? CW'(ci_q + 1'b1) : CW'(ci_q - 1'b1);
				end
				st_d = ST_MV_RD;
			end
			ST_BLANK: begin
				// the vacated row or cell is where the move loop stopped
				we    = 1'b1;
				waddr = cell_addr(line_q ? ri_q : y_q, ci_q);
				wdata = ste_pkg::C_SPACE;
				if (line_q && (ci_q != wm1_q)) begin
					ci_d = ci_q + 1'b1;
				end else begin
					st_d = ST_IDLE;
					emit = 1'b1;
				end
			end
			default: st_d = ST_IDLE;
		endcase

		if (cfg_we) begin
			unique case (cfg_index)
				ste_pkg::CFG_COLS: begin
					nw    = CW'(ste_pkg::eff_last(int'(cfg_data), MAX_COLS));
					wm1_d = nw;
					if (x_q > nw) begin
						x_d = nw;
					end
				end
				ste_pkg::CFG_ROWS: begin
					nh    = RW'(ste_pkg::eff_last(int'(cfg_data[5:0]), MAX_ROWS));
					hm1_d = nh;
					if (y_q > nh) begin
						y_d = nh;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_SWEEP;
			sweep_q <= '0;
			fill_q  <= ste_pkg::C_SPACE;
			clr_q   <= 1'b0;
			x_q     <= '0;
			y_q     <= '0;
			esc_q   <= 1'b0;
			wm1_q   <= CW'(ste_pkg::eff_last(ste_pkg::COLS_RESET, MAX_COLS));
			hm1_q   <= RW'(ste_pkg::eff_last(ste_pkg::ROWS_RESET, MAX_ROWS));
			ov_q    <= 1'b0;
		end else begin
			st_q    <= st_d;
			sweep_q <= sweep_d;
			fill_q  <= fill_d;
			clr_q   <= clr_d;
			x_q     <= x_d;
			y_q     <= y_d;
			esc_q   <= esc_d;
			wm1_q   <= wm1_d;
			hm1_q   <= hm1_d;
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		line_q  <= line_d;
		fwd_q   <= fwd_d;
		ri_q    <= ri_d;
		ci_q    <= ci_d;
		stopr_q <= stopr_d;
		stopc_q <= stopc_d;
		rd_ok_q <= rd_ok_d;
		if (emit) begin
			cell_q <= e_cell;
			cx_q   <= 6'(x_d);
			cy_q   <= 5'(y_d);
			bell_q <= e_bell;
			esca_q <= esc_d;
		end
	end

	assign cmd_pop      = take;
	assign out_valid    = ov_q;
	assign cell_value   = cell_q;
	assign cursor_col   = cx_q;
	assign cursor_row   = cy_q;
	assign bell         = bell_q;
	assign escape_armed = esca_q;
	assign sts.busy     = (st_q != ST_IDLE);
	assign sts.in_area  = (x_q <= wm1_q) && (y_q <= hm1_q);

endmodule

// ----- rtl/text_screen_editor_engine.sv -----
`timescale 1ns / 1ps
// top level of the character-cell text terminal engine
// depends on ste_pkg, ste_front, ste_back (which holds ste_ram)
//
// Usage: items enter on in_valid/in_ready; operation 0 puts char_code, 1 reads
// the cell at read_row/read_col. Every item gives one result on out_valid/out_ready
// with the cell (reads), cursor after the item, bell and the escape flag.
// columns and rows are written on cfg_we/cfg_index/cfg_data by the user only while
// no item is open; the block does not enforce this. A two entry queue sits between
// the decoder and the executor, so up to two items are taken while a result waits;
// a stalled receiver holds its result and the executor takes no new item until
// that result is gone. Plain bytes and cursor moves pass the queue and result
// registers, 1 item per cycle sustained while every result is taken; reads also
// pass the registered store read. Line delete/insert and scroll copy each moved
// row cell by cell, then blank a row; character delete/insert copy the moved
// cells, then blank one, each copy a read then a write on the single store port
// pair (one read and one write per cycle). Clear sweeps all MAX_ROWS*MAX_COLS
// cells (2048 by default); after arst_n rises it writes spaces; items wait for it.
module text_screen_editor_engine #(
	parameter int MAX_COLS = ste_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = ste_pkg::DEF_MAX_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic [7:0] char_code,
	input  logic       display_raw,
	input  logic [4:0] read_row,
	input  logic [5:0] read_col,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] cell_value,
	output logic [5:0] cursor_col,
	output logic [4:0] cursor_row,
	output logic       bell,
	output logic       escape_armed
);

	logic          cmd_valid;
	logic          cmd_pop;
	ste_pkg::cmd_t cmd;
	ste_pkg::sts_t sts;

	ste_front #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.char_code  (char_code),
		.display_raw(display_raw),
		.read_row   (read_row),
		.read_col   (read_col),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd)
	);

	ste_back #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cell_value  (cell_value),
		.cursor_col  (cursor_col),
		.cursor_row  (cursor_row),
		.bell        (bell),
		.escape_armed(escape_armed),
		.sts         (sts)
	);

	// cursor never leaves the active area
	a_cursor_in_area: assert property (@(posedge clk) disable iff (!arst_n)
		sts.in_area)
		else $error("cursor outside active area");

	// a multi-cycle operation only runs with the result slot empty
	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> !out_valid)
		else $error("result pending during store operation");

	// a bell result carries no cell and no armed escape
	a_bell_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bell) |-> (cell_value == 8'h00 && !escape_armed))
		else $error("bell result with cell or escape set");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for text_screen_editor_engine: directed table, then random text
// depends on ste_pkg and the rtl of the block; results are checked against a local screen model or typed table values
module tb_top;

	typedef struct {
		logic [7:0] cval;
		logic [5:0] ccol;
		logic [4:0] crow;
		logic       bell;
		logic       esc;
	} term_out_t;

	typedef struct {
		logic       op;
		logic [7:0] ch;
		logic       raw;
		logic [4:0] rr;
		logic [5:0] rc;
		bit         typed;
		term_out_t  res;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       operation = 1'b0;
	logic [7:0] char_code = '0;
	logic       display_raw = 1'b0;
	logic [4:0] read_row = '0;
	logic [5:0] read_col = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] cell_value;
	logic [5:0] cursor_col;
	logic [4:0] cursor_row;
	logic       bell;
	logic       escape_armed;

	text_screen_editor_engine dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// screen model state
	logic [7:0] screen[ste_pkg::DEF_MAX_ROWS][ste_pkg::DEF_MAX_COLS];
	int         cur_x, cur_y, reg_cols, reg_rows;
	bit         esc_flag;

	term_out_t  pending_q[$];
	int         errors = 0;
	bit         quiet = 1'b0;
	bit         hold_req = 1'b0;
	int         hold_cnt = 0;

	function automatic int act_w();
		if (reg_cols == 0) return 1;
		return reg_cols > ste_pkg::DEF_MAX_COLS ? ste_pkg::DEF_MAX_COLS : reg_cols;
	endfunction

	function automatic int act_h();
		if (reg_rows == 0) return 1;
		return reg_rows > ste_pkg::DEF_MAX_ROWS ? ste_pkg::DEF_MAX_ROWS : reg_rows;
	endfunction

	function automatic void clamp_cur();
		if (cur_x >= act_w()) cur_x = act_w() - 1;
		if (cur_y >= act_h()) cur_y = act_h() - 1;
	endfunction

	function automatic void move_row(int dst, int src);
		for (int c = 0; c < act_w(); c++) screen[dst][c] = screen[src][c];
	endfunction

	function automatic void blank_row(int r);
		for (int c = 0; c < act_w(); c++) screen[r][c] = ste_pkg::C_SPACE;
	endfunction

	function automatic void line_feed();
		cur_y++;
		if (cur_y >= act_h()) begin
			for (int r = 0; r + 1 < act_h(); r++) move_row(r, r + 1);
			blank_row(act_h() - 1);
			cur_y = act_h() - 1;
		end
	endfunction

	function automatic void write_glyph(logic [7:0] c);
		screen[cur_y][cur_x] = c;
		cur_x++;
		if (cur_x >= act_w()) begin
			cur_x = 0;
			line_feed();
		end
	endfunction

	function automatic term_out_t screen_step(logic op, logic [7:0] c, logic raw,
			logic [4:0] rr, logic [5:0] rc);
		term_out_t o;
		int w, h;
		o.cval = '0;
		o.bell = 1'b0;
		clamp_cur();
		w = act_w();
		h = act_h();
		if (op == ste_pkg::OP_READ) begin
			o.cval = screen[rr][rc];
		end else if (esc_flag) begin
			esc_flag = 1'b0;
			write_glyph(c);
		end else if (c != ste_pkg::C_EOL && raw) begin
			write_glyph(c);
		end else begin
			case (c)
				ste_pkg::C_ESC: esc_flag = 1'b1;
				ste_pkg::C_UP: cur_y = cur_y ? cur_y - 1 : h - 1;
				ste_pkg::C_DOWN: cur_y = (cur_y + 1 >= h) ? 0 : cur_y + 1;
				ste_pkg::C_LEFT: cur_x = cur_x ? cur_x - 1 : w - 1;
				ste_pkg::C_RIGHT: cur_x = (cur_x + 1 >= w) ? 0 : cur_x + 1;
				ste_pkg::C_CLEAR: begin
					foreach (screen[r, k]) screen[r][k] = ste_pkg::FILL_CLEAR;
					cur_x = 0;
					cur_y = 0;
				end
				ste_pkg::C_BS: begin
					screen[cur_y][cur_x] = ste_pkg::C_SPACE;
					if (cur_x) cur_x--;
				end
				ste_pkg::C_EOL: begin
					cur_x = 0;
					line_feed();
				end
				ste_pkg::C_DELLN: begin
					for (int i = cur_y; i + 1 < h; i++) move_row(i, i + 1);
					blank_row(h - 1);
				end
				ste_pkg::C_INSLN: begin
					for (int i = h - 1; i > cur_y; i--) move_row(i, i - 1);
					blank_row(cur_y);
				end
				ste_pkg::C_BELL: o.bell = 1'b1;
				ste_pkg::C_DELCH: begin
					for (int i = cur_x; i + 1 < w; i++) screen[cur_y][i] = screen[cur_y][i + 1];
					screen[cur_y][w - 1] = ste_pkg::C_SPACE;
				end
				ste_pkg::C_INSCH: begin
					for (int i = w - 1; i > cur_x; i--) screen[cur_y][i] = screen[cur_y][i - 1];
					screen[cur_y][cur_x] = ste_pkg::C_SPACE;
				end
				default: write_glyph(c);
			endcase
		end
		o.ccol = cur_x[5:0];
		o.crow = cur_y[4:0];
		o.esc = esc_flag;
		return o;
	endfunction

	task automatic send_item(stim_row_t s);
		term_out_t p;
		if (!quiet && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= s.op;
		char_code <= s.ch;
		display_raw <= s.raw;
		read_row <= s.rr;
		read_col <= s.rc;
		do @(posedge clk); while (!in_ready);
		p = screen_step(s.op, s.ch, s.raw, s.rr, s.rc);
		pending_q.push_back(s.typed ? s.res : p);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [6:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == ste_pkg::CFG_COLS) reg_cols = int'(val);
		else reg_rows = int'(val[5:0]);
		clamp_cur();
	endtask

	function automatic stim_row_t mk(logic op, logic [7:0] ch, logic raw, logic [4:0] rr,
			logic [5:0] rc, bit typed = 0, logic [7:0] ec = 0, logic [5:0] ex = 0,
			logic [4:0] ey = 0, logic eb = 0, logic ee = 0);
		stim_row_t s;
		s.op = op; s.ch = ch; s.raw = raw; s.rr = rr; s.rc = rc; s.typed = typed;
		s.res.cval = ec; s.res.ccol = ex; s.res.crow = ey; s.res.bell = eb; s.res.esc = ee;
		return s;
	endfunction

	function automatic stim_row_t rand_item();
		stim_row_t s;
		int pick;
		s = mk(0, 0, 0, 5'($urandom), 6'($urandom));
		if ($urandom_range(99) < 20) begin
			s.op = ste_pkg::OP_READ;
			if ($urandom_range(99) < 70) begin
				s.rr = 5'($urandom_range(act_h() - 1));
				s.rc = 6'($urandom_range(act_w() - 1));
			end
			return s;
		end
		s.ch = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 60) begin
			s.ch = 8'($urandom_range(8'h21, 8'h7C));
		end else if (pick < 88) begin
			case ($urandom_range(12))
				0: s.ch = ste_pkg::C_ESC;
				1: s.ch = ste_pkg::C_UP;
				2: s.ch = ste_pkg::C_DOWN;
				3: s.ch = ste_pkg::C_LEFT;
				4: s.ch = ste_pkg::C_RIGHT;
				5: s.ch = ste_pkg::C_BS;
				6: s.ch = ste_pkg::C_EOL;
				7: s.ch = ste_pkg::C_DELLN;
				8: s.ch = ste_pkg::C_INSLN;
				9: s.ch = ste_pkg::C_BELL;
				10: s.ch = ste_pkg::C_DELCH;
				11: s.ch = ste_pkg::C_INSCH;
				default: s.ch = ste_pkg::C_CLEAR;
			endcase
		end
		s.raw = ($urandom_range(99) < 10);
		// clear sweeps the whole store, keep it rare
		if (s.ch == ste_pkg::C_CLEAR && !s.raw && $urandom_range(9) != 0)
			s.ch = ste_pkg::C_SPACE;
		return s;
	endfunction

	// result side: check, random stall and the long hold-off
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result cell=%h col=%0d row=%0d", $time,
					cell_value, cursor_col, cursor_row);
				errors++;
			end else begin
				term_out_t e;
				e = pending_q.pop_front();
				if (cell_value !== e.cval) begin
					$display("%0t: cell_value exp %h got %h", $time, e.cval, cell_value);
					errors++;
				end
				if (cursor_col !== e.ccol) begin
					$display("%0t: cursor_col exp %0d got %0d", $time, e.ccol, cursor_col);
					errors++;
				end
				if (cursor_row !== e.crow) begin
					$display("%0t: cursor_row exp %0d got %0d", $time, e.crow, cursor_row);
					errors++;
				end
				if (bell !== e.bell) begin
					$display("%0t: bell exp %b got %b", $time, e.bell, bell);
					errors++;
				end
				if (escape_armed !== e.esc) begin
					$display("%0t: escape_armed exp %b got %b", $time, e.esc, escape_armed);
					errors++;
				end
			end
		end
		if (hold_req && hold_cnt == 0) begin
			hold_cnt = 400;
			hold_req = 1'b0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 6);
		end
	end

	initial begin
		stim_row_t dir_tab[$];
		logic [6:0] phase_cols[8] = '{40, 1, 64, 0, 127, 8, 17, 3};
		logic [6:0] phase_rows[8] = '{24, 1, 32, 0, 127, 4, 9, 31};
		foreach (screen[r, k]) screen[r][k] = ste_pkg::C_SPACE;
		cur_x = 0; cur_y = 0; esc_flag = 0;
		reg_cols = ste_pkg::COLS_RESET; reg_rows = ste_pkg::ROWS_RESET;

		dir_tab.push_back(mk(1, 0, 0, 0, 0, 1, ste_pkg::C_SPACE, 0, 0, 0, 0));
		dir_tab.push_back(mk(1, 0, 0, 31, 63, 1, ste_pkg::C_SPACE, 0, 0, 0, 0));
		dir_tab.push_back(mk(0, 8'h41, 0, 0, 0, 1, 0, 1, 0, 0, 0));
		dir_tab.push_back(mk(0, ste_pkg::C_BELL, 0, 0, 0, 1, 0, 1, 0, 1, 0));
		dir_tab.push_back(mk(0, ste_pkg::C_ESC, 0, 0, 0, 1, 0, 1, 0, 0, 1));
		// end-of-line under escape lands as a glyph
		dir_tab.push_back(mk(0, ste_pkg::C_EOL, 0, 0, 0, 1, 0, 2, 0, 0, 0));
		dir_tab.push_back(mk(1, 0, 0, 0, 1, 1, ste_pkg::C_EOL, 2, 0, 0, 0));
		dir_tab.push_back(mk(0, ste_pkg::C_BELL, 1, 0, 0));
		dir_tab.push_back(mk(0, ste_pkg::C_EOL, 1, 0, 0));
		dir_tab.push_back(mk(0, ste_pkg::C_UP, 0, 0, 0));
		dir_tab.push_back(mk(0, ste_pkg::C_LEFT, 0, 0, 0));
		dir_tab.push_back(mk(0, ste_pkg::C_RIGHT, 0, 0, 0));
		dir_tab.push_back(mk(0, ste_pkg::C_DOWN, 0, 0, 0));
		dir_tab.push_back(mk(0, 8'hFF, 1, 0, 0));
		dir_tab.push_back(mk(0, ste_pkg::C_INSCH, 0, 0, 0));
		dir_tab.push_back(mk(0, ste_pkg::C_DELCH, 0, 0, 0));
		dir_tab.push_back(mk(0, ste_pkg::C_BS, 0, 0, 0));
		dir_tab.push_back(mk(0, ste_pkg::C_INSLN, 0, 0, 0));
		dir_tab.push_back(mk(0, ste_pkg::C_DELLN, 0, 0, 0));
		dir_tab.push_back(mk(0, ste_pkg::C_ESC, 0, 0, 0));
		// clear under escape lands as a glyph at row 1 column 0
		dir_tab.push_back(mk(0, ste_pkg::C_CLEAR, 0, 0, 0, 1, 0, 1, 1, 0, 0));
		dir_tab.push_back(mk(0, ste_pkg::C_CLEAR, 0, 0, 0));
		dir_tab.push_back(mk(1, 0, 0, 31, 63, 1, ste_pkg::FILL_CLEAR, 0, 0, 0, 0));
		dir_tab.push_back(mk(0, 8'h00, 1, 0, 0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) send_item(dir_tab[i]);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(ste_pkg::CFG_COLS, phase_cols[ph]);
			write_reg(ste_pkg::CFG_ROWS, phase_rows[ph]);
			for (int n = 0; n < 190; n++) begin
				quiet = (ph == 3);
				if (ph == 1 && n == 50) hold_req = 1'b1;
				if (ph == 5 && n == 100) begin
					in_valid <= 1'b0;
					while (pending_q.size() != 0) @(posedge clk);
				end
				send_item(rand_item());
			end
			quiet = 1'b0;
			drain();
		end

		repeat (50) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0)
			$display("text_screen_editor_engine verification clean");
		else
			$display("text_screen_editor_engine verification failed");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("text_screen_editor_engine verification failed");
		$finish;
	end

endmodule
